// ----- hdl/me64_pkg.sv -----
// me64_pkg: shared constants and types for the 64-bit modular exponentiator
// used by the interfaces, the modular step unit, the sequencer and the top level
package me64_pkg;

  localparam int FIELD_BITS = 64;
  localparam int WORD_BITS_DEFAULT = 64;

  // step unit operations
  localparam logic OP_DBL = 1'b0;
  localparam logic OP_ADD = 1'b1;

  typedef struct packed {
    logic clear;
    logic step;
    logic op;
    logic bit_in;
  } unit_ctrl_t;

endpackage

// ----- hdl/me64_in_if.sv -----
// me64_in_if: operand channel of the modular exponentiator
// depends on me64_pkg for the field width
interface me64_in_if;
  logic                           valid;
  logic                           ready;
  logic [me64_pkg::FIELD_BITS-1:0] base_value;
  logic [me64_pkg::FIELD_BITS-1:0] exponent;
  logic [me64_pkg::FIELD_BITS-1:0] modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink (input valid, input base_value, input exponent, input modulus,
                output ready);
endinterface

// ----- hdl/me64_out_if.sv -----
// me64_out_if: result channel of the modular exponentiator
// depends on me64_pkg for the field width
interface me64_out_if;
  logic                           valid;
  logic                           ready;
  logic [me64_pkg::FIELD_BITS-1:0] power_result;
  logic                           zero_modulus_error;

  modport source (output valid, output power_result, output zero_modulus_error,
                  input ready);
  modport sink (input valid, input power_result, input zero_modulus_error,
                output ready);
endinterface

// ----- hdl/me64_unit.sv -----
// me64_unit: shared modular step unit with its accumulator register
// one step is a double-and-shift-in or an add, each followed by one conditional subtract
// depends on me64_pkg
module me64_unit #(
  parameter int W = me64_pkg::WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  me64_pkg::unit_ctrl_t ctrl,
  input  logic [W-1:0]         addend,
  input  logic [W-1:0]         m,
  output logic [W-1:0]         acc
);

  logic [W:0]   t;
  logic [W+1:0] diff;
  logic [W-1:0] acc_next;

  always_comb begin
    if (ctrl.op == me64_pkg::OP_ADD) begin
      t = {1'b0, acc} + {1'b0, addend};
    end else begin
      t = {acc, ctrl.bit_in};
    end
    diff = {1'b0, t} - {2'b00, m};
    acc_next = diff[W+1] ? t[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.step) begin
      acc <= acc_next;
    end
  end

`ifndef SYNTH
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |=> acc < m)
    else $error("step unit left a residue not below the modulus");
`endif

endmodule

// ----- hdl/me64_seq.sv -----
// me64_seq: sequencer for right-to-left square and multiply
// drives the shared step unit bit by bit; holds base, exponent, modulus and residues
// depends on me64_pkg and me64_unit
module me64_seq #(
  parameter int W = me64_pkg::WORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [W-1:0]                     base_in,
  input  logic [W-1:0]                     exp_in,
  input  logic [W-1:0]                     mod_in,
  output logic                             done_valid,
  input  logic                             done_ready,
  output logic [me64_pkg::FIELD_BITS-1:0]  done_result,
  output logic                             done_err
);

  localparam int CW = $clog2(W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_LDSQ = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_DBL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam logic MODE_MUL = 1'b0;
  localparam logic MODE_SQR = 1'b1;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic          mode;
  logic [W-1:0]  b_reg;
  logic [W-1:0]  e_reg;
  logic [W-1:0]  m_reg;
  logic [W-1:0]  sq;
  logic [W-1:0]  res;
  logic [W-1:0]  mb;
  logic          err;

  me64_pkg::unit_ctrl_t ctrl;
  logic [W-1:0]         acc;

  me64_unit #(.W(W)) u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .addend (sq),
    .m      (m_reg),
    .acc    (acc)
  );

  assign in_ready    = (state == S_IDLE);
  assign done_valid  = (state == S_FIN);
  assign done_err    = err;
  assign done_result = err ? '0 : me64_pkg::FIELD_BITS'(res);

  always_comb begin
    ctrl = '0;
    ctrl.op = me64_pkg::OP_DBL;
    unique case (state)
      S_IDLE: begin
        ctrl.clear = in_valid;
      end
      S_RED: begin
        ctrl.step   = 1'b1;
        ctrl.bit_in = b_reg[W-1];
      end
      S_EXP: begin
        ctrl.clear = (e_reg != '0);
      end
      S_DBL: begin
        ctrl.step = 1'b1;
      end
      S_ADD: begin
        ctrl.step = 1'b1;
        ctrl.op   = me64_pkg::OP_ADD;
      end
      S_END: begin
        ctrl.clear = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            b_reg <= base_in;
            e_reg <= exp_in;
            m_reg <= mod_in;
            res   <= W'(1);
            cnt   <= CW'(W - 1);
            err   <= (mod_in == '0);
            state <= (mod_in == '0) ? S_FIN : S_RED;
          end
        end
        S_RED: begin
          b_reg <= b_reg << 1;
          if (cnt == '0) begin
            state <= S_LDSQ;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_LDSQ: begin
          sq    <= acc;
          state <= S_EXP;
        end
        S_EXP: begin
          cnt <= CW'(W - 1);
          if (e_reg == '0) begin
            state <= S_FIN;
          end else if (e_reg[0]) begin
            mb    <= res;
            mode  <= MODE_MUL;
            state <= S_DBL;
          end else begin
            mb    <= sq;
            mode  <= MODE_SQR;
            state <= S_DBL;
          end
        end
        S_DBL, S_ADD: begin
          if (state == S_DBL && mb[W-1]) begin
            state <= S_ADD;
          end else begin
            mb <= mb << 1;
            if (cnt == '0) begin
              state <= S_END;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= S_DBL;
            end
          end
        end
        S_END: begin
          cnt <= CW'(W - 1);
          if (mode == MODE_MUL) begin
            res <= acc;
            if (e_reg[W-1:1] == '0) begin
              state <= S_FIN;
            end else begin
              mb    <= sq;
              mode  <= MODE_SQR;
              state <= S_DBL;
            end
          end else begin
            sq    <= acc;
            e_reg <= e_reg >> 1;
            state <= S_EXP;
          end
        end
        S_FIN: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_zero_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && mod_in == '0) |=> (state == S_FIN && err))
    else $error("zero modulus did not go straight to the flagged result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN) |-> !ctrl.step)
    else $error("step unit stepped outside a job");

  a_ldsq_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDSQ) |-> ($past(state) == S_RED && $past(cnt) == '0))
    else $error("reduced base taken before the reduction finished");

  a_res_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !err && $past(state) == S_END) |-> res < m_reg)
    else $error("multiplied result not below the modulus");
`endif

endmodule

// ----- hdl/modular_exponentiation_64.sv -----
// modular_exponentiation_64: base^exponent mod modulus, one job at a time
// a zero modulus goes straight to a flagged result; otherwise the base is first reduced, and an
// exponent of zero ends there; each exponent bit below the highest set one adds a square, and
// each set bit adds a multiply, all run on the shared step unit
// a new beat is taken once the result is registered
// reset: synchronous active-high rst returns the sequencer to idle and empties the output
module modular_exponentiation_64 #(
  parameter int WORD_BITS = me64_pkg::WORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  me64_in_if.sink     operands,
  me64_out_if.source  result
);

  logic                            done_valid;
  logic                            done_ready;
  logic [me64_pkg::FIELD_BITS-1:0] done_result;
  logic                            done_err;
  logic                            out_valid;
  logic [me64_pkg::FIELD_BITS-1:0] out_result;
  logic                            out_err;

  me64_seq #(.W(WORD_BITS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (operands.valid),
    .in_ready    (operands.ready),
    .base_in     (operands.base_value[WORD_BITS-1:0]),
    .exp_in      (operands.exponent[WORD_BITS-1:0]),
    .mod_in      (operands.modulus[WORD_BITS-1:0]),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .done_result (done_result),
    .done_err    (done_err)
  );

  // output register
  assign done_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (done_valid && done_ready) begin
        out_valid  <= 1'b1;
        out_result <= done_result;
        out_err    <= done_err;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid              = out_valid;
  assign result.power_result       = out_result;
  assign result.zero_modulus_error = out_err;

endmodule
